@@ rtl/tdnp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdnp_pkg
// Shared types and fixed field widths for the trial division number
// properties block.
// ----------------------------------------------------------------------------
package tdnp_pkg;

    // result field widths
    localparam int PRIME_W     = 1;
    localparam int DTOT_W      = 11;
    localparam int TOP_W       = 31;
    localparam int OUT_FIELD_W = PRIME_W + DTOT_W + TOP_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture the input word, clear the counters
        logic div_start;   // launch one trial division
        logic sel_top;     // divide the reduced value instead of the input
        logic cnt_update;  // fold a division result into the divisor count
        logic top_init;    // start the largest factor pass
        logic strip2;      // remove one factor of two
        logic top_update;  // fold a division result into the factor pass
        logic top_finish;  // take the leftover cofactor if it is a prime
        logic out_load;    // move the results into the output register
    } tdnp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic neg_zero;    // input is zero or negative
        logic div_done;    // division result available
        logic bound_ok;    // trial divisor is at most the quotient
        logic fresh;       // first division with the current trial divisor
        logic m_even;      // reduced value still even
        logic out_full;    // output register holds an untaken word
    } tdnp_status_t;

endpackage
`default_nettype wire

@@ rtl/trial_division_number_properties.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_number_properties
// Primality, divisor count and largest prime factor of a signed integer,
// found by trial division with a shared serial divider.
//
//   channel  dir  payload (low bit first)
//   s_       in   tdata: value
//   m_       out  tdata: prime_flag, divisor_total, top_prime_factor
//
// An item runs about floor(sqrt(n)) divisions for the count pass and up to
// sqrt(n)/2 more for the factor pass in the bit-serial divider; zero and
// negative values skip both passes.
// One item is worked at a time; the next is taken while a result waits.
// Reset is synchronous and clears the sequencer, divider and output valid.
// ----------------------------------------------------------------------------
module trial_division_number_properties
    import tdnp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // value
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // prime_flag, divisor_total, top_prime_factor
    output logic [OUT_TDATA_W-1:0]                    m_tdata
);

    tdnp_cmd_t    cmd;
    tdnp_status_t status;

    tdnp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdnp_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .value    (s_tdata[VALUE_WIDTH-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

@@ rtl/tdnp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdnp_div
// Restoring unsigned divider, one quotient bit per cycle. Quotient and
// remainder hold until the next start.
// ----------------------------------------------------------------------------
module tdnp_div #(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic      [WIDTH-1:0] quot,
    output logic      [WIDTH-1:0] rem
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    // one shift and trial subtract
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next = CNT_W'(WIDTH);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
            if (!diff[WIDTH]) begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

@@ rtl/tdnp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdnp_datapath
// Operand, counter and factor registers around one shared divider, plus the
// output register.
// ----------------------------------------------------------------------------
module tdnp_datapath
    import tdnp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire tdnp_cmd_t              cmd,
    output tdnp_status_t                status,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int W  = VALUE_WIDTH;
    localparam int IW = VALUE_WIDTH / 2 + 2;
    localparam int CW = VALUE_WIDTH / 2 + 2;

    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  top_reg, top_next;
    logic [IW-1:0] i_reg, i_next;
    logic [CW-1:0] c_reg, c_next;
    logic          fresh_reg, fresh_next;
    logic          valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;

    logic          div_done;
    logic [W-1:0]  quot;
    logic [W-1:0]  rem;
    logic [W-1:0]  i_ext;
    logic [W-1:0]  dividend;
    logic          quot_eq;

    logic [CW+DTOT_W-1:0] c_wide;
    logic [W+TOP_W-1:0]   top_wide;

    assign i_ext    = {{(W-IW){1'b0}}, i_reg};
    assign dividend = cmd.sel_top ? m_reg : n_reg;
    assign quot_eq  = (quot == i_ext);

    tdnp_div #(
        .WIDTH(W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (i_ext),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    // fit the counters to the fixed output fields
    assign c_wide   = {{DTOT_W{1'b0}}, c_reg};
    assign top_wide = {{TOP_W{1'b0}}, top_reg};

    // advance the working registers on command
    always_comb begin
        n_next     = n_reg;
        m_next     = m_reg;
        top_next   = top_reg;
        i_next     = i_reg;
        c_next     = c_reg;
        fresh_next = fresh_reg;
        if (cmd.load) begin
            n_next   = value;
            i_next   = IW'(1);
            c_next   = '0;
            top_next = W'(1);
        end
        if (cmd.cnt_update) begin
            if (rem == '0) begin
                c_next = c_reg + (quot_eq ? CW'(1) : CW'(2));
            end
            i_next = i_reg + IW'(1);
        end
        if (cmd.top_init) begin
            m_next     = n_reg;
            top_next   = W'(1);
            i_next     = IW'(3);
            fresh_next = 1'b1;
        end
        if (cmd.strip2) begin
            m_next   = {1'b0, m_reg[W-1:1]};
            top_next = W'(2);
        end
        if (cmd.top_update) begin
            if (rem == '0) begin
                top_next   = i_ext;
                m_next     = quot;
                fresh_next = 1'b0;
            end else begin
                i_next     = i_reg + IW'(2);
                fresh_next = 1'b1;
            end
        end
        if (cmd.top_finish && (m_reg > W'(2))) begin
            top_next = m_reg;
        end
    end

    // hold the result word until it is taken
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            valid_next = 1'b1;
            data_next  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                          top_wide[TOP_W-1:0],
                          c_wide[DTOT_W-1:0],
                          (c_reg == CW'(2))};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        n_reg     <= n_next;
        m_reg     <= m_next;
        top_reg   <= top_next;
        i_reg     <= i_next;
        c_reg     <= c_next;
        fresh_reg <= fresh_next;
        data_reg  <= data_next;
    end

    assign status.neg_zero = n_reg[W-1] || (n_reg == '0);
    assign status.div_done = div_done;
    assign status.bound_ok = (i_ext <= quot);
    assign status.fresh    = fresh_reg;
    assign status.m_even   = !m_reg[0];
    assign status.out_full = valid_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
`default_nettype wire

@@ rtl/tdnp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdnp_ctrl
// Sequencer for the two trial division passes: divisor count with primality,
// then largest prime factor.
// ----------------------------------------------------------------------------
module tdnp_ctrl
    import tdnp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire tdnp_status_t status,
    output tdnp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CNT_START,
        ST_CNT_WAIT,
        ST_TOP_INIT,
        ST_STRIP,
        ST_TOP_START,
        ST_TOP_WAIT,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign accept = s_tvalid && ready_reg;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.neg_zero ? ST_OUT : ST_CNT_START;
            end
            // divisor count pass
            ST_CNT_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_CNT_WAIT;
            end
            ST_CNT_WAIT: begin
                if (status.div_done) begin
                    if (status.bound_ok) begin
                        cmd.cnt_update = 1'b1;
                        state_next     = ST_CNT_START;
                    end else begin
                        state_next = ST_TOP_INIT;
                    end
                end
            end
            // largest factor pass
            ST_TOP_INIT: begin
                cmd.top_init = 1'b1;
                state_next   = ST_STRIP;
            end
            ST_STRIP: begin
                if (status.m_even) begin
                    cmd.strip2 = 1'b1;
                end else begin
                    state_next = ST_TOP_START;
                end
            end
            ST_TOP_START: begin
                cmd.div_start = 1'b1;
                cmd.sel_top   = 1'b1;
                state_next    = ST_TOP_WAIT;
            end
            ST_TOP_WAIT: begin
                cmd.sel_top = 1'b1;
                if (status.div_done) begin
                    if (status.fresh && !status.bound_ok) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.top_update = 1'b1;
                        state_next     = ST_TOP_START;
                    end
                end
            end
            ST_FINISH: begin
                cmd.top_finish = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_full) begin
                    cmd.out_load = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule
`default_nettype wire

@@ rtl/tdnp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdnp_checker
// Port-level checks on the trial division number properties block.
// ----------------------------------------------------------------------------
module tdnp_checker
    import tdnp_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // one item in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // a prime has exactly two divisors
    a_prime_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[DTOT_W:1] == DTOT_W'(2))
        else $error("prime flag with wrong divisor count");

    // results appear only at the end of an item's work
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while input side was idle");

endmodule

bind trial_division_number_properties tdnp_checker u_tdnp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/trial_division_number_properties_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_number_properties_chk
// Passive checker for the trial division block. It watches both stream
// channels, computes primality, divisor count and largest prime factor for
// every accepted input word, and compares each output word in order.
// ----------------------------------------------------------------------------
module trial_division_number_properties_chk
    import tdnp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    input  wire logic                                 s_tready,
    // value
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    // prime_flag, divisor_total, top_prime_factor
    input  wire logic [OUT_TDATA_W-1:0]               m_tdata,
    output int                                        mismatches,
    output int                                        pending
);

    // one output word, prime flag in the lowest bits
    typedef struct packed {
        logic [TOP_W-1:0]  top_factor;
        logic [DTOT_W-1:0] divisors;
        logic              prime;
    } props_t;

    props_t props_due[$];

    function automatic logic odd_prime_test(longint unsigned n);
        longint unsigned d;
        if (n < 2) return 1'b0;
        if (n == 2) return 1'b1;
        if (n[0] == 1'b0) return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // pair each divisor below the root with its cofactor; the root counts once
    function automatic longint unsigned divisor_pairs(longint unsigned n);
        longint unsigned d;
        longint unsigned total;
        total = 0;
        for (d = 1; d <= n / d; d++) begin
            if (n % d == 0) total += (n / d == d) ? 1 : 2;
        end
        return total;
    endfunction

    // strip factors in rising order; a leftover above two is itself prime
    function automatic longint unsigned largest_factor(longint unsigned n);
        longint unsigned d;
        longint unsigned best;
        best = 1;
        if (n <= 1) return 1;
        while (n[0] == 1'b0) begin
            best = 2;
            n = n >> 1;
        end
        for (d = 3; d <= n / d; d += 2) begin
            while (n % d == 0) begin
                best = d;
                n = n / d;
            end
        end
        if (n > 2) best = n;
        return best;
    endfunction

    function automatic props_t number_props(logic [VALUE_WIDTH-1:0] value);
        props_t          p;
        longint unsigned n;
        p.prime      = 1'b0;
        p.divisors   = '0;
        p.top_factor = TOP_W'(1);
        // zero and negative words carry the fixed answer
        if (value[VALUE_WIDTH-1] || value == '0) return p;
        n            = longint'(value);
        p.prime      = odd_prime_test(n);
        p.divisors   = DTOT_W'(divisor_pairs(n));
        p.top_factor = TOP_W'(largest_factor(n));
        return p;
    endfunction

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    // queue on input acceptance, compare on output acceptance
    always @(posedge aclk) begin
        props_t want;
        props_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                props_due.push_back(number_props(s_tdata[VALUE_WIDTH-1:0]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_FIELD_W-1:0];
                if (props_due.size() == 0) begin
                    $display("%0t unexpected word: expected none, got %h", $time, got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = props_due.pop_front();
                    if (got.prime !== want.prime || got.divisors !== want.divisors ||
                        got.top_factor !== want.top_factor) begin
                        $display("%0t mismatch: expected prime %0d div %0d top %0d, got prime %0d div %0d top %0d",
                                 $time, want.prime, want.divisors, want.top_factor,
                                 got.prime, got.divisors, got.top_factor);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= props_due.size();
        end
    end

endmodule

@@ tb/trial_division_number_properties_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_number_properties_tb
// Stimulus and verdict for the trial division block: directed edge values,
// then random signed words weighted toward small magnitudes, with random
// idling on both channels and one long output hold-off. A separate checker
// does all prediction and comparison.
// ----------------------------------------------------------------------------
module trial_division_number_properties_tb
    import tdnp_pkg::*;
();

    localparam int VW          = 32;
    localparam int S_W         = ((VW + 7) / 8) * 8;
    localparam int RAND_WORDS  = 80;
    localparam int CALM_WORDS  = 15;
    localparam int SQUEEZE_CYC = 3000;
    localparam int QUIET_LIMIT = 400000;
    localparam int DRAIN_CYC   = 200;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    bit idling;
    bit squeeze_req;

    trial_division_number_properties #(
        .VALUE_WIDTH(VW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    trial_division_number_properties_chk #(
        .VALUE_WIDTH(VW)
    ) chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // offer one word, with an optional gap first; return at its acceptance edge
    task automatic send_word(input logic [VW-1:0] value);
        if (idling && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(value);
        do @(posedge aclk); while (!s_tready);
    endtask

    // random value, mostly small positives so the trial loops stay short
    function automatic logic [VW-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return $urandom() | 32'h8000_0000;
        if (pick < 30) return VW'($urandom_range(0, 2));
        if (pick < 70) return VW'($urandom_range(1, 1023));
        if (pick < 95) return VW'($urandom_range(1024, 65535));
        return VW'($urandom_range(65536, 1048575));
    endfunction

    // output side: one long hold-off on request, else random bursts
    initial begin : sink
        bit squeezed;
        squeezed = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (squeeze_req && !squeezed) begin
                squeezed = 1'b1;
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYC) @(posedge aclk);
            end else if (idling && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // end the run when no word moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [VW-1:0] directed[$];
        idling      = 1'b1;
        squeeze_req = 1'b0;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        repeat (4) @(posedge aclk);
        aresetn    <= 1'b1;

        // zero, one, two, small primes and squares, negatives, powers of two,
        // highly composite values and a prime times a large prime cofactor
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF,
                     32'h8000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF ^ 32'hFFFF_FFFF,
                     32'd9, 32'd25, 32'd36, 32'd961, 32'd97, 32'd1024,
                     32'd210, 32'd55440, 32'd65521, 32'd65536, 32'd1048574,
                     32'd1048573};

        // hold the output off while the first words pile up
        squeeze_req = 1'b1;
        foreach (directed[k]) send_word(directed[k]);

        for (int k = 0; k < RAND_WORDS; k++) begin
            if (k == RAND_WORDS - CALM_WORDS) idling = 1'b0;
            send_word(random_value());
        end
        s_tvalid <= 1'b0;

        // drain, then keep watching for any stray word
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ trial_division_number_properties.f @@
rtl/tdnp_pkg.sv
rtl/tdnp_div.sv
rtl/tdnp_datapath.sv
rtl/tdnp_ctrl.sv
rtl/trial_division_number_properties.sv
rtl/tdnp_checker.sv
tb/trial_division_number_properties_chk.sv
tb/trial_division_number_properties_tb.sv
